### sv/uart_tx_rx_ring_buffers_unit_defines.svh
// Assertion macros used by the checker of the UART ring buffer unit.
`ifndef UART_TX_RX_RING_BUFFERS_UNIT_DEFINES_SVH
`define UART_TX_RX_RING_BUFFERS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UTRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uart ring buffer check failed");

// Next-cycle implication, disabled while reset is high.
`define UTRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uart ring buffer check failed");

`endif

### sv/uart_trb_pkg.sv
package uart_trb_pkg;

  localparam int DEFAULT_DEPTH = 16;

  // Entries of the command queue between the front and the back.
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  typedef enum logic [1:0] {
    REQ_SEND   = 2'd0,
    REQ_READ   = 2'd1,
    REQ_READY  = 2'd2,
    REQ_ARRIVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TX_FULL    = 2'd1,
    ST_RX_EMPTY   = 2'd2,
    ST_RX_OVERRUN = 2'd3
  } status_t;

  typedef struct packed {
    req_t       req;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    status_t    status;
  } result_t;

endpackage

### sv/uart_trb_front.sv
module uart_trb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type,
  input  logic [7:0]          data_byte,
  output uart_trb_pkg::cmd_t  cmd,
  output logic                cmd_valid,
  input  logic                q_ready
);

  logic hold_valid;
  logic accept;
  logic move;

  assign move      = hold_valid && q_ready;
  assign full      = hold_valid && !q_ready;
  assign accept    = push && !full;
  assign cmd_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  // Only sends and arrivals carry a byte; the others keep a clean zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.req <= uart_trb_pkg::req_t'(req_type);
      if (uart_trb_pkg::req_t'(req_type) == uart_trb_pkg::REQ_SEND ||
          uart_trb_pkg::req_t'(req_type) == uart_trb_pkg::REQ_ARRIVE) begin
        cmd.data <= data_byte;
      end else begin
        cmd.data <= 8'd0;
      end
    end
  end

endmodule

### sv/uart_trb_cmdq.sv
module uart_trb_cmdq (
  input  logic                clk,
  input  logic                rst,
  input  uart_trb_pkg::cmd_t  in_cmd,
  input  logic                in_valid,
  output logic                in_ready,
  output uart_trb_pkg::cmd_t  out_cmd,
  output logic                out_valid,
  input  logic                out_take
);

  localparam int AW = uart_trb_pkg::CQ_AW;

  uart_trb_pkg::cmd_t    slots [uart_trb_pkg::CQ_DEPTH];
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         rd_ptr;
  logic [AW:0]           count;
  logic                  wr_en;
  logic                  rd_en;

  assign in_ready  = count != (AW+1)'(uart_trb_pkg::CQ_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slots[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_take && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

### sv/uart_trb_back.sv
module uart_trb_back #(
  parameter int DEPTH = uart_trb_pkg::DEFAULT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  uart_trb_pkg::cmd_t     cmd,
  input  logic                   cmd_valid,
  output logic                   cmd_take,
  output uart_trb_pkg::result_t  res,
  output logic                   res_valid,
  input  logic                   pop
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  typedef enum logic {S_EXEC, S_FETCH} state_t;

  state_t                 state;
  logic                   fetch_tx;
  logic [PW-1:0]          tx_rd;
  logic [PW-1:0]          tx_wr;
  logic [PW-1:0]          rx_rd;
  logic [PW-1:0]          rx_wr;
  logic                   tx_idle;

  logic [7:0]             tx_mem [DEPTH];
  logic [7:0]             rx_mem [DEPTH];
  logic [7:0]             tx_q;
  logic [7:0]             rx_q;

  logic [PW-1:0]          tx_wr_inc;
  logic [PW-1:0]          tx_rd_inc;
  logic [PW-1:0]          rx_wr_inc;
  logic [PW-1:0]          rx_rd_inc;
  logic                   tx_empty;
  logic                   tx_full;
  logic                   rx_empty;
  logic                   rx_full;
  logic                   res_free;
  logic                   tx_we;
  logic                   rx_we;
  logic                   tx_rd_adv;
  logic                   rx_rd_adv;
  logic                   fetch;
  uart_trb_pkg::result_t  res_now;
  uart_trb_pkg::result_t  res_fetch;

  assign tx_wr_inc = (tx_wr == LAST) ? '0 : tx_wr + 1'b1;
  assign tx_rd_inc = (tx_rd == LAST) ? '0 : tx_rd + 1'b1;
  assign rx_wr_inc = (rx_wr == LAST) ? '0 : rx_wr + 1'b1;
  assign rx_rd_inc = (rx_rd == LAST) ? '0 : rx_rd + 1'b1;

  assign tx_empty = tx_rd == tx_wr;
  assign tx_full  = tx_wr_inc == tx_rd;
  assign rx_empty = rx_rd == rx_wr;
  assign rx_full  = rx_wr_inc == rx_rd;

  // The result register is free when empty or when its beat leaves this cycle.
  assign res_free = !res_valid || pop;
  assign cmd_take = (state == S_EXEC) && cmd_valid && res_free;

  assign tx_we     = cmd_take && cmd.req == uart_trb_pkg::REQ_SEND && !tx_idle && !tx_full;
  assign rx_we     = cmd_take && cmd.req == uart_trb_pkg::REQ_ARRIVE && !rx_full;
  assign tx_rd_adv = cmd_take && cmd.req == uart_trb_pkg::REQ_READY && !tx_empty;
  assign rx_rd_adv = cmd_take && cmd.req == uart_trb_pkg::REQ_READ && !rx_empty;
  assign fetch     = tx_rd_adv || rx_rd_adv;

  // Results that need no ring read.
  always_comb begin
    res_now = '0;
    res_now.status = uart_trb_pkg::ST_OK;
    unique case (cmd.req)
      uart_trb_pkg::REQ_SEND: begin
        if (tx_idle) begin
          res_now.line_valid = 1'b1;
          res_now.line_byte  = cmd.data;
        end else if (tx_full) begin
          res_now.status = uart_trb_pkg::ST_TX_FULL;
        end
      end
      uart_trb_pkg::REQ_READ: begin
        if (rx_empty) begin
          res_now.status = uart_trb_pkg::ST_RX_EMPTY;
        end
      end
      uart_trb_pkg::REQ_READY: begin
      end
      uart_trb_pkg::REQ_ARRIVE: begin
        if (rx_full) begin
          res_now.status = uart_trb_pkg::ST_RX_OVERRUN;
        end
      end
      default: begin
      end
    endcase
  end

  // Result of a fetch, built from the byte that the ring read port returned.
  always_comb begin
    res_fetch            = '0;
    res_fetch.status     = uart_trb_pkg::ST_OK;
    res_fetch.line_valid = fetch_tx;
    res_fetch.line_byte  = fetch_tx ? tx_q : 8'd0;
    res_fetch.read_valid = !fetch_tx;
    res_fetch.read_byte  = fetch_tx ? 8'd0 : rx_q;
  end

  // The read port follows the read pointer, so the data is ready in the cycle after issue.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wr] <= cmd.data;
    end
    tx_q <= tx_mem[tx_rd];
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wr] <= cmd.data;
    end
    rx_q <= rx_mem[rx_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_EXEC;
      res_valid <= 1'b0;
      tx_rd     <= '0;
      tx_wr     <= '0;
      rx_rd     <= '0;
      rx_wr     <= '0;
      tx_idle   <= 1'b0;
    end else begin
      // A beat is loaded by a direct result or at the end of a fetch.
      if (state == S_FETCH || (cmd_take && !fetch)) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (tx_we) begin
        tx_wr <= tx_wr_inc;
      end
      if (rx_we) begin
        rx_wr <= rx_wr_inc;
      end
      if (tx_rd_adv) begin
        tx_rd <= tx_rd_inc;
      end
      if (rx_rd_adv) begin
        rx_rd <= rx_rd_inc;
      end
      if (cmd_take) begin
        if (cmd.req == uart_trb_pkg::REQ_SEND) begin
          tx_idle <= 1'b0;
        end else if (cmd.req == uart_trb_pkg::REQ_READY) begin
          tx_idle <= tx_empty;
        end
      end
      unique case (state)
        S_EXEC: begin
          if (cmd_take) begin
            if (fetch) begin
              state    <= S_FETCH;
              fetch_tx <= tx_rd_adv;
            end else begin
              res <= res_now;
            end
          end
        end
        S_FETCH: begin
          res   <= res_fetch;
          state <= S_EXEC;
        end
        default: begin
          state <= S_EXEC;
        end
      endcase
    end
  end

endmodule

### sv/uart_tx_rx_ring_buffers_unit.sv
// Channel   Direction  Handshake               Payload
// request   in         push / full             req_type, data_byte
// result    out        pop / empty             line_valid, line_byte, read_valid,
//                                              read_byte, status
//
// Every request gives one result beat. A request passes an input register and a
// two-entry command queue, then the executing stage. Sends, arrivals and requests
// that find a ring full or empty are answered there; reads and ready events that
// fetch a byte pass a fetch state, set by the registered ring read port.
// Sustained rate: one request a cycle while results are popped; a fetch holds off
// the next. Reset is synchronous and clears pointers, the idle flag and handshake
// valid flags, not ring contents. A held result stalls every stage behind it.
module uart_tx_rx_ring_buffers_unit #(
  parameter int DEPTH = uart_trb_pkg::DEFAULT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic       line_valid,
  output logic [7:0] line_byte,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic [1:0] status
);

  uart_trb_pkg::cmd_t     front_cmd;
  logic                   front_valid;
  logic                   q_ready;
  uart_trb_pkg::cmd_t     q_cmd;
  logic                   q_valid;
  logic                   q_take;
  uart_trb_pkg::result_t  res;
  logic                   res_valid;

  uart_trb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .data_byte (data_byte),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .q_ready   (q_ready)
  );

  uart_trb_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (front_cmd),
    .in_valid  (front_valid),
    .in_ready  (q_ready),
    .out_cmd   (q_cmd),
    .out_valid (q_valid),
    .out_take  (q_take)
  );

  uart_trb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_take  (q_take),
    .res       (res),
    .res_valid (res_valid),
    .pop       (pop)
  );

  assign empty      = !res_valid;
  assign line_valid = res.line_valid;
  assign line_byte  = res.line_byte;
  assign read_valid = res.read_valid;
  assign read_byte  = res.read_byte;
  assign status     = res.status;

endmodule

### sv/uart_trb_checker.sv
`include "uart_tx_rx_ring_buffers_unit_defines.svh"

module uart_trb_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       line_valid,
  input logic [7:0] line_byte,
  input logic       read_valid,
  input logic [7:0] read_byte,
  input logic [1:0] status
);

  logic [19:0] beat;
  logic        status_ok;

  assign beat      = {line_valid, line_byte, read_valid, read_byte, status};
  assign status_ok = status == uart_trb_pkg::ST_OK;

  // A beat never carries a line byte and a read byte together.
  `UTRB_ASSERT_IMPL(a_one_byte_kind, clk, rst, !empty, !(line_valid && read_valid))

  // A beat with a non-ok status hands out no byte.
  `UTRB_ASSERT_IMPL(a_status_no_byte, clk, rst, !empty && !status_ok, !line_valid && !read_valid)

  // Byte fields are zero when their valid flag is low.
  `UTRB_ASSERT_IMPL(a_zero_line_byte, clk, rst, !empty && !line_valid, line_byte == 8'd0)
  `UTRB_ASSERT_IMPL(a_zero_read_byte, clk, rst, !empty && !read_valid, read_byte == 8'd0)

  // A beat that is not taken stays in place.
  `UTRB_ASSERT_NEXT(a_hold_beat, clk, rst, !empty && !pop, !empty && $stable(beat))

endmodule

bind uart_tx_rx_ring_buffers_unit uart_trb_checker u_trb_checker (.*);
